/* hdl/rxf_pkg.sv */
package rxf_pkg;

    localparam int COORD_W = 9;
    localparam int COUNT_W = 17;
    localparam int CHUNK_W = 8;
    localparam int PCNT_W  = 4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_ROWS,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic setup;
        logic row_step;
        logic sum_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic rows_done;
        logic sum_last;
    } t_status;

    function automatic logic [PCNT_W-1:0] f_popcount8(input logic [CHUNK_W-1:0] v);
        logic [PCNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            cnt = cnt + PCNT_W'(v[i]);
        end
        return cnt;
    endfunction

endpackage

/* hdl/rxf_datapath.sv */
module rxf_datapath
    import rxf_pkg::*;
#(
    parameter int GRID_SIZE = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic signed [COORD_W-1:0] i_left_x,
    input  logic signed [COORD_W-1:0] i_bottom_y,
    input  logic signed [COORD_W-1:0] i_right_x,
    input  logic signed [COORD_W-1:0] i_top_y,
    output logic        [COUNT_W-1:0] o_toggled_count
);

    localparam int IW     = $clog2(GRID_SIZE);
    localparam int CW     = ((IW + 1 > COORD_W) ? IW + 1 : COORD_W) + 2;
    localparam int NCHUNK = (GRID_SIZE + CHUNK_W - 1) / CHUNK_W;
    localparam int PW     = NCHUNK * CHUNK_W;
    localparam int ACC_W  = $clog2(CHUNK_W * GRID_SIZE + 1);
    localparam int SUM_W  = $clog2(GRID_SIZE * GRID_SIZE + 1);
    localparam int TW     = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;
    localparam int SCW    = $clog2(NCHUNK + 1);

    localparam logic signed [CW-1:0] HALF_S = CW'(GRID_SIZE / 2);
    localparam logic signed [CW-1:0] MAX_S  = CW'(GRID_SIZE - 1);
    localparam logic signed [CW-1:0] ONE_S  = CW'(1);
    localparam logic        [IW-1:0] MAX_I  = IW'(GRID_SIZE - 1);

    function automatic logic [IW-1:0] f_clip(input logic signed [CW-1:0] v);
        logic [IW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > MAX_S) begin
            res = MAX_I;
        end else begin
            res = v[IW-1:0];
        end
        return res;
    endfunction

    logic [GRID_SIZE-1:0] r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_mem_q;

    logic signed [CW-1:0] ext_left, ext_bottom, ext_right, ext_top;
    logic signed [CW-1:0] c_lo, c_hi, r_lo, r_hi;
    logic                 n_hit;

    logic [IW-1:0] r_c_lo, r_c_hi, r_r_lo, r_r_hi;
    logic          r_hit;

    logic [GRID_SIZE-1:0] r_mask;
    logic [IW:0]          r_width;
    logic [IW:0]          n_width;
    logic [GRID_SIZE-1:0] ones;

    logic [IW-1:0] r_rd_addr;
    logic          r_rd_more;
    logic [IW-1:0] r_wb_addr;
    logic          r_wb_valid;
    logic [IW-1:0] r_clr_addr;

    logic                 rd_en, wr_en;
    logic [IW-1:0]        wr_addr;
    logic [GRID_SIZE-1:0] wr_data;

    logic [PW-1:0]     hit_bits;
    logic [PCNT_W-1:0] pcnt [NCHUNK];
    logic [ACC_W-1:0]  r_acc [NCHUNK];
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_area;
    logic [SCW-1:0]    r_sum_cnt;

    logic [TW-1:0] r_total;
    logic [TW+1:0] total_calc;

    always_comb begin
        ext_left   = CW'(i_left_x);
        ext_bottom = CW'(i_bottom_y);
        ext_right  = CW'(i_right_x);
        ext_top    = CW'(i_top_y);
        c_lo = ext_left + HALF_S;
        c_hi = ext_right + HALF_S - ONE_S;
        r_lo = HALF_S - ext_top;
        r_hi = HALF_S - ext_bottom - ONE_S;
        n_hit = (ext_right > ext_left) && (ext_top > ext_bottom) &&
                (c_hi >= 0) && (c_lo <= MAX_S) && (r_hi >= 0) && (r_lo <= MAX_S);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c_lo <= f_clip(c_lo);
            r_c_hi <= f_clip(c_hi);
            r_r_lo <= f_clip(r_lo);
            r_r_hi <= f_clip(r_hi);
            r_hit  <= n_hit;
        end
    end

    assign ones    = '1;
    assign n_width = {1'b0, r_c_hi} - {1'b0, r_c_lo} + (IW + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mask  <= (ones << r_c_lo) & (ones >> (MAX_I - r_c_hi));
            r_width <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_more  <= 1'b0;
            r_wb_valid <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + IW'(1);
            end
            if (i_cmd.setup) begin
                r_rd_more  <= r_hit;
                r_wb_valid <= 1'b0;
            end else if (i_cmd.row_step) begin
                r_wb_valid <= r_rd_more;
                if (r_rd_more && (r_rd_addr == r_r_hi)) begin
                    r_rd_more <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_rd_addr <= r_r_lo;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + IW'(1);
            r_wb_addr <= r_rd_addr;
        end
    end

    assign rd_en   = i_cmd.row_step && r_rd_more;
    assign wr_en   = i_cmd.clear || (i_cmd.row_step && r_wb_valid);
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_wb_addr;
    assign wr_data = i_cmd.clear ? '0 : (r_mem_q ^ r_mask);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_addr];
        end
    end

    assign hit_bits = PW'(r_mem_q & r_mask);

    always_comb begin
        for (int k = 0; k < NCHUNK; k++) begin
            pcnt[k] = f_popcount8(hit_bits[k*CHUNK_W +: CHUNK_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            for (int k = 0; k < NCHUNK; k++) begin
                r_acc[k] <= '0;
            end
            r_area    <= '0;
            r_sum     <= '0;
            r_sum_cnt <= '0;
        end else if (i_cmd.row_step && r_wb_valid) begin
            for (int k = 0; k < NCHUNK; k++) begin
                r_acc[k] <= r_acc[k] + ACC_W'(pcnt[k]);
            end
            r_area <= r_area + SUM_W'(r_width);
        end else if (i_cmd.sum_step) begin
            for (int k = 0; k < NCHUNK; k++) begin
                if (k == NCHUNK - 1) begin
                    r_acc[k] <= '0;
                end else begin
                    r_acc[k] <= r_acc[k+1];
                end
            end
            r_sum     <= r_sum + SUM_W'(r_acc[0]);
            r_sum_cnt <= r_sum_cnt + SCW'(1);
        end
    end

    assign total_calc = (TW + 2)'(r_total) + (TW + 2)'(r_area) - ((TW + 2)'(r_sum) << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.commit) begin
            r_total <= total_calc[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_toggled_count <= total_calc[COUNT_W-1:0];
        end
    end

    always_comb begin
        o_status.clr_last  = (r_clr_addr == MAX_I);
        o_status.rows_done = !r_rd_more && !r_wb_valid;
        o_status.sum_last  = (r_sum_cnt == SCW'(NCHUNK - 1));
    end

endmodule

/* hdl/rxf_ctrl.sv */
module rxf_ctrl
    import rxf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_ROWS;
            ST_ROWS: begin
                if (i_status.rows_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (i_status.sum_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_ROWS:  o_cmd.row_step = !i_status.rows_done;
            ST_SUM:   o_cmd.sum_step = 1'b1;
            ST_DONE:  o_cmd.commit = out_free;
            default: begin
                o_cmd      = '0;
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/rectangle_xor_fill_counter.sv */
// Each accepted rectangle inverts the grid cells strictly inside it, clipped to the grid, and
// returns one transfer holding the number of grid cells that are set afterwards. The grid is
// stored as one GRID_SIZE-bit word per row in a single memory, and one row is read, inverted
// under the column mask, counted and written back per cycle. After acceptance an item passes
// through a setup step, the row steps over the covered rows after clipping (none for an empty
// or outside rectangle), a summing phase that drains the per-byte bit counters and a done step
// that commits the count. The done step repeats while the previous count still waits in the
// output register under stall. After reset the block stalls its input while it clears the
// grid one row per cycle. A finished count waits in the output register while the next
// rectangle is taken in.
module rectangle_xor_fill_counter
    import rxf_pkg::*;
#(
    parameter int GRID_SIZE = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [COORD_W-1:0] i_left_x,
    input  logic signed [COORD_W-1:0] i_bottom_y,
    input  logic signed [COORD_W-1:0] i_right_x,
    input  logic signed [COORD_W-1:0] i_top_y,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic        [COUNT_W-1:0] o_toggled_count
);

    t_cmd    cmd;
    t_status status;

    rxf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rxf_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_left_x        (i_left_x),
        .i_bottom_y      (i_bottom_y),
        .i_right_x       (i_right_x),
        .i_top_y         (i_top_y),
        .o_toggled_count (o_toggled_count)
    );

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer taken while an item was still in progress");

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result committed over a pending output transfer");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.setup, cmd.row_step, cmd.sum_step, cmd.commit}))
        else $error("more than one datapath command at once");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import rxf_pkg::*;

    localparam int GRID_SIZE = 256;
    localparam int HALF      = GRID_SIZE / 2;
    localparam int N_DIR     = 25;
    localparam int N_RAND    = 800;
    localparam int MAX_CYC   = 2_000_000;

    typedef struct packed {
        int lx;
        int by;
        int rx;
        int ty;
        bit fixed;
        int cnt;
    } t_rect_vec;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_left_x = '0;
    logic signed [COORD_W-1:0] i_bottom_y = '0;
    logic signed [COORD_W-1:0] i_right_x = '0;
    logic signed [COORD_W-1:0] i_top_y = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic        [COUNT_W-1:0] o_toggled_count;

    bit [GRID_SIZE-1:0] grid_rows [GRID_SIZE];
    int                 cells_on = 0;
    logic [COUNT_W-1:0] count_q [$];
    logic [COUNT_W-1:0] want_cnt;

    int src_idle_pct = 13;
    int dst_idle_pct = 68;
    int err_cnt = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_empty = 0;
    int n_beyond = 0;
    int cycle_cnt = 0;

    // Corners are left, bottom, right, top; the last two columns give a typed-in count.
    t_rect_vec dir_tab [N_DIR] = '{
        '{0, 0, 0, 0, 1'b1, 0},
        '{-128, -128, 128, 128, 1'b1, 65536},
        '{-128, -128, 128, 128, 1'b1, 0},
        '{-1, -1, 1, 1, 1'b1, 4},
        '{-1, -1, 1, 1, 1'b1, 0},
        '{10, 0, 3, 10, 1'b1, 0},
        '{5, 0, 5, 10, 1'b1, 0},
        '{0, 7, 10, -3, 1'b1, 0},
        '{-256, -256, 255, 255, 1'b1, 65536},
        '{-256, -256, 255, 255, 1'b1, 0},
        '{130, 0, 200, 10, 1'b1, 0},
        '{-250, -20, -129, 20, 1'b1, 0},
        '{0, 128, 10, 200, 1'b1, 0},
        '{0, -255, 10, -129, 1'b1, 0},
        '{-128, 127, -127, 128, 1'b1, 1},
        '{127, -128, 128, -127, 1'b1, 2},
        '{120, -5, 200, 5, 1'b1, 82},
        '{-128, -128, 128, 128, 1'b1, 65454},
        '{-128, -128, 128, 128, 1'b1, 82},
        '{-100, -100, 100, 100, 1'b0, 0},
        '{-50, -60, 70, 80, 1'b0, 0},
        '{-3, -90, 4, 90, 1'b0, 0},
        '{0, 0, 1, 1, 1'b0, 0},
        '{-128, -128, 128, 128, 1'b0, 0},
        '{-100, -100, 100, 100, 1'b0, 0}
    };

    rectangle_xor_fill_counter #(
        .GRID_SIZE(GRID_SIZE)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_x       (i_left_x),
        .i_bottom_y     (i_bottom_y),
        .i_right_x      (i_right_x),
        .i_top_y        (i_top_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_toggled_count(o_toggled_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_idx(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > GRID_SIZE - 1) begin
            return GRID_SIZE - 1;
        end
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] flip_rect(input logic signed [COORD_W-1:0] l,
                                                     input logic signed [COORD_W-1:0] b,
                                                     input logic signed [COORD_W-1:0] r,
                                                     input logic signed [COORD_W-1:0] t);
        int c_lo, c_hi, r_lo, r_hi;
        logic [GRID_SIZE-1:0] mask;
        if (l < -128 || l > 128 || b < -128 || b > 128 ||
            r < -128 || r > 128 || t < -128 || t > 128) begin
            n_beyond++;
        end
        if (r > l && t > b) begin
            c_lo = int'(l) + HALF;
            c_hi = int'(r) + HALF - 1;
            r_lo = HALF - int'(t);
            r_hi = HALF - int'(b) - 1;
            if (c_hi >= 0 && c_lo <= GRID_SIZE - 1 && r_hi >= 0 && r_lo <= GRID_SIZE - 1) begin
                c_lo = clamp_idx(c_lo);
                c_hi = clamp_idx(c_hi);
                r_lo = clamp_idx(r_lo);
                r_hi = clamp_idx(r_hi);
                mask = '0;
                for (int c = c_lo; c <= c_hi; c++) begin
                    mask[c] = 1'b1;
                end
                for (int rr = r_lo; rr <= r_hi; rr++) begin
                    cells_on = cells_on - $countones(grid_rows[rr]);
                    grid_rows[rr] = grid_rows[rr] ^ mask;
                    cells_on = cells_on + $countones(grid_rows[rr]);
                end
            end
        end else begin
            n_empty++;
        end
        return COUNT_W'(cells_on);
    endfunction

    task automatic send_rect(input int l, input int b, input int r, input int t,
                             input bit fixed, input int cnt);
        logic signed [COORD_W-1:0] lx, by, rx, ty;
        logic [COUNT_W-1:0] cnt_pred;
        lx = COORD_W'(l);
        by = COORD_W'(b);
        rx = COORD_W'(r);
        ty = COORD_W'(t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_x   <= lx;
        i_bottom_y <= by;
        i_right_x  <= rx;
        i_top_y    <= ty;
        do @(posedge i_clk); while (o_in_stall);
        cnt_pred = flip_rect(lx, by, rx, ty);
        count_q.push_back(fixed ? COUNT_W'(cnt) : cnt_pred);
        n_sent++;
    endtask

    task automatic pick_rect(output int l, output int b, output int r, output int t);
        int kind, w, h, tmp;
        kind = $urandom_range(0, 99);
        l = int'($urandom_range(0, 256)) - 128;
        b = int'($urandom_range(0, 256)) - 128;
        r = int'($urandom_range(0, 256)) - 128;
        t = int'($urandom_range(0, 256)) - 128;
        if (kind < 55) begin
            if (r < l) begin
                tmp = l;
                l = r;
                r = tmp;
            end
            if (t < b) begin
                tmp = b;
                b = t;
                t = tmp;
            end
        end else if (kind < 75) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
            l = int'($urandom_range(0, 256 - w)) - 128;
            b = int'($urandom_range(0, 256 - h)) - 128;
            r = l + w;
            t = b + h;
        end else if (kind < 85) begin
            if ($urandom_range(0, 1) == 0) begin
                l = -128;
                r = 128;
                b = int'($urandom_range(0, 255)) - 128;
                t = b + 1 + int'($urandom_range(0, 127 - b));
            end else begin
                b = -128;
                t = 128;
                l = int'($urandom_range(0, 255)) - 128;
                r = l + 1 + int'($urandom_range(0, 127 - l));
            end
        end else if (kind < 92) begin
            if ($urandom_range(0, 1) == 0) begin
                r = l - int'($urandom_range(0, 20));
            end else begin
                t = b - int'($urandom_range(0, 20));
            end
        end else begin
            l = int'($urandom_range(0, 511));
            b = int'($urandom_range(0, 511));
            r = int'($urandom_range(0, 511));
            t = int'($urandom_range(0, 511));
            l = (l > 255) ? l - 512 : l;
            b = (b > 255) ? b - 512 : b;
            r = (r > 255) ? r - 512 : r;
            t = (t > 255) ? t - 512 : t;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (count_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (count_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("Unexpected count transfer: got %0d", o_toggled_count);
                end
            end else begin
                want_cnt = count_q.pop_front();
                if (o_toggled_count !== want_cnt) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("Count mismatch at transfer %0d: expected %0d, got %0d",
                                 n_checked, want_cnt, o_toggled_count);
                    end
                end
            end
            n_checked++;
        end
    end

    initial begin
        while (cycle_cnt < MAX_CYC) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int l, b, r, t;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIR; k++) begin
            send_rect(dir_tab[k].lx, dir_tab[k].by, dir_tab[k].rx, dir_tab[k].ty,
                      dir_tab[k].fixed, dir_tab[k].cnt);
        end
        for (int ph = 0; ph < 3; ph++) begin
            wait_drained();
            src_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 68 : 0;
            dst_idle_pct <= (ph == 0) ? 68 : (ph == 1) ? 13 : 0;
            for (int n = 0; n < N_RAND / 3; n++) begin
                pick_rect(l, b, r, t);
                send_rect(l, b, r, t, 1'b0, 0);
            end
        end
        wait_drained();
        repeat (GRID_SIZE + 64) @(posedge i_clk);
        $display("Applied %0d rectangles (%0d empty, %0d with corners past the grid edge).",
                 n_sent, n_empty, n_beyond);
        $display("Checked %0d count transfers over %0d cycles; %0d mismatches.",
                 n_checked, cycle_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/rxf_pkg.sv
hdl/rxf_datapath.sv
hdl/rxf_ctrl.sv
hdl/rectangle_xor_fill_counter.sv
sim/tb_top.sv
